>>> rtl/core/assert_macros.svh
// Assertion macros shared by the interpolator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/uvi_pkg.sv
// Types and constants of the UV nearest-neighbor vertex interpolator.
package uvi_pkg;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_NOP   = 2'd3;

  // Stored entry: pos x/y/z, normal x/y/z, tex u/v from the lowest bit up.
  localparam int ENT_W = 192;
  localparam int D_W = 51;           // squared UV distance, units of 2^-32
  localparam logic [D_W-1:0] EPS = D_W'(4295);
  localparam int WFRAC = 24;
  localparam logic signed [15:0] NORM_ONE = 16'sd16384;
  localparam int NUM_COMP = 8;

  // Shared divider and square root widths.
  localparam int DIV_W = 76;
  localparam int DVS_W = 52;
  localparam int SQ_IN_W = 64;
  localparam int SQ_OUT_W = 32;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_NEAR_RD,
    ST_NEAR_CAP,
    ST_W_RD,
    ST_W_GO,
    ST_W_WAIT,
    ST_MAC,
    ST_A_GO,
    ST_A_WAIT,
    ST_SQ,
    ST_LEN,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_N_GO,
    ST_N_WAIT,
    ST_OUT
  } state_t;

endpackage

>>> rtl/core/uvi_ram.sv
// Generic simple dual-port RAM with registered read data.
module uvi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/uvi_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module uvi_div #(
  parameter int DW = 76,
  parameter int VW = 52
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt;
  logic [DW-1:0] dvd;
  logic [VW-1:0] dvs;
  logic [VW-1:0] rem;
  logic [VW:0]   trial;
  logic          take;

  // Shift in the next dividend bit and try a subtract.
  assign trial = {rem, dvd[DW-1]};
  assign take  = trial >= {1'b0, dvs};

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd      <= {dvd[DW-2:0], 1'b0};
      quotient <= {quotient[DW-2:0], take};
      rem      <= take ? VW'(trial - {1'b0, dvs}) : trial[VW-1:0];
    end
  end

endmodule

>>> rtl/core/uvi_isqrt.sv
// Iterative integer square root, rounding down, two radicand bits per cycle.
module uvi_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [uvi_pkg::SQ_IN_W-1:0]  radicand,
  output logic                         done,
  output logic [uvi_pkg::SQ_OUT_W-1:0] root
);

  import uvi_pkg::*;

  localparam int CW = $clog2(SQ_OUT_W + 1);

  logic [CW-1:0]      cnt;
  logic               busy;
  logic [SQ_IN_W-1:0] x;
  logic [SQ_IN_W-1:0] r;
  logic [SQ_IN_W-1:0] b;
  logic [SQ_IN_W-1:0] sum;
  logic               ge;

  assign sum  = r + b;
  assign ge   = x >= sum;
  assign root = r[SQ_OUT_W-1:0];

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(SQ_OUT_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Digit-by-digit root.
  always_ff @(posedge clk) begin
    if (start) begin
      x <= radicand;
      r <= '0;
      b <= {2'b01, {(SQ_IN_W-2){1'b0}}};
    end else if (busy) begin
      if (ge) begin
        x <= x - sum;
        r <= (r >> 1) + b;
      end else begin
        r <= r >> 1;
      end
      b <= b >> 2;
    end
  end

endmodule

>>> rtl/core/uv_nearest_three_idw_interpolator.sv
// Clear and load items are handled in the idle state; a query's time is set by one pass
// over the vertex RAM read port plus the shared bit-serial divider (NEAREST_COUNT+11 divides).
// Items are taken one at a time; a load or clear may enter while a result waits.
// Synchronous reset empties the table at once; the RAM gets no clearing pass.
`include "assert_macros.svh"

module uv_nearest_three_idw_interpolator #(
  parameter int MAX_ENTRIES   = 4096,
  parameter int NEAREST_COUNT = 3
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v, query_u, query_v
  input  logic [239:0] s_tdata,
  // kind
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z, out_u, out_v
  output logic [191:0] m_tdata,
  // table_empty
  output logic [0:0]   m_tuser
);

  import uvi_pkg::*;

  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int SLOT_W = (NEAREST_COUNT > 1) ? $clog2(NEAREST_COUNT) : 1;
  localparam int K_W    = $clog2(NEAREST_COUNT + 1);
  localparam int TOT_W  = WFRAC + 1 + $clog2(NEAREST_COUNT + 1);

  state_t state, state_next;

  logic [CNT_W-1:0]  entry_count;
  logic              s_acc;
  logic              near;
  logic              scan_last;
  logic signed [23:0] qu, qv;
  logic [CNT_W-1:0]  scan_addr;

  // RAM ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;

  // Scan pipeline.
  logic              rd_issue;
  logic              p0_v, p1_v;
  logic [ADDR_W-1:0] p0_idx, p1_idx;
  logic [49:0]       sq_u, sq_v;
  logic signed [24:0] du, dv;
  logic [D_W-1:0]    d_new;

  // Sorted list of the nearest entries.
  logic [D_W-1:0]    bd [NEAREST_COUNT];
  logic [ADDR_W-1:0] bi [NEAREST_COUNT];
  logic [NEAREST_COUNT-1:0] sv;
  logic [NEAREST_COUNT-1:0] lt;

  // Weighting and accumulation.
  logic [K_W-1:0]    k;
  logic              k_last;
  logic [WFRAC:0]    w;
  logic [3:0]        comp_idx;
  logic signed [31:0] comp_val;
  logic signed [63:0] prod;
  logic              prod_v;
  logic [2:0]        prod_c;
  logic signed [63:0] acc [NUM_COMP];
  logic [TOT_W-1:0]  tot;
  logic [ENT_W-1:0]  ent;

  // Normalization.
  logic signed [16:0] nrm [3];
  logic [33:0]       nsq [3];
  logic [35:0]       len2_sum;
  logic [35:0]       len2;
  logic [SQ_OUT_W-1:0] len;
  logic [16:0]       nmag;

  // Shared divider and root unit.
  logic              div_start, div_busy, div_done, div_neg, div_neg_next;
  logic [DIV_W-1:0]  div_dividend, div_quo;
  logic [DVS_W-1:0]  div_divisor;
  logic signed [63:0] div_res;
  logic signed [63:0] nclamp;
  logic [63:0]       acc_mag;
  logic              sq_start, sq_done;
  logic [SQ_OUT_W-1:0] sq_root;

  logic [ENT_W-1:0]  res_word;
  logic              res_empty;

  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign near      = entry_count <= CNT_W'(NEAREST_COUNT);
  assign scan_last = (scan_addr + CNT_W'(1)) == entry_count;
  assign k_last    = k == K_W'(NEAREST_COUNT - 1);
  assign ram_we    = s_acc && (s_tuser == KIND_LOAD) && (entry_count < CNT_W'(MAX_ENTRIES));

  uvi_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(entry_count[ADDR_W-1:0]),
    .wdata(s_tdata[ENT_W-1:0]),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  uvi_div #(
    .DW(DIV_W),
    .VW(DVS_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_quo)
  );

  uvi_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .radicand(SQ_IN_W'({len2, 28'b0})),
    .done    (sq_done),
    .root    (sq_root)
  );

  // Distance of the entry in the read register to the query point.
  assign du    = $signed({ram_rdata[167], ram_rdata[167:144]}) - $signed({qu[23], qu});
  assign dv    = $signed({ram_rdata[191], ram_rdata[191:168]}) - $signed({qv[23], qv});
  assign d_new = D_W'(sq_u) + D_W'(sq_v);

  // Slots that the new distance goes before; an empty slot counts as infinite.
  always_comb begin
    for (int p = 0; p < NEAREST_COUNT; p++) begin
      lt[p] = !sv[p] || (d_new < bd[p]);
    end
  end

  // Component of the fetched entry for the multiply-accumulate.
  always_comb begin
    case (comp_idx[2:0])
      3'd0: comp_val = $signed(ent[31:0]);
      3'd1: comp_val = $signed(ent[63:32]);
      3'd2: comp_val = $signed(ent[95:64]);
      3'd3: comp_val = 32'(signed'(ent[111:96]));
      3'd4: comp_val = 32'(signed'(ent[127:112]));
      3'd5: comp_val = 32'(signed'(ent[143:128]));
      3'd6: comp_val = 32'(signed'(ent[167:144]));
      default: comp_val = 32'(signed'(ent[191:168]));
    endcase
  end

  // Signed divider result and normal clamp.
  assign div_res  = div_neg ? -$signed(div_quo[63:0]) : $signed(div_quo[63:0]);
  assign nclamp   = (div_res > 64'sd16384) ? 64'sd16384 :
                    (div_res < -64'sd16384) ? -64'sd16384 : div_res;
  assign acc_mag  = acc[comp_idx[2:0]][63] ? 64'(-acc[comp_idx[2:0]])
                                           : 64'(acc[comp_idx[2:0]]);
  assign nmag     = nrm[comp_idx[1:0]][16] ? 17'(-nrm[comp_idx[1:0]])
                                           : 17'(nrm[comp_idx[1:0]]);
  assign len2_sum = 36'(nsq[0]) + 36'(nsq[1]) + 36'(nsq[2]);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_acc && (s_tuser == KIND_QUERY)) begin
          state_next = (entry_count == '0) ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: if (scan_last) state_next = ST_DRAIN;
      ST_DRAIN: begin
        if (!p0_v && !p1_v) state_next = near ? ST_NEAR_RD : ST_W_RD;
      end
      ST_NEAR_RD:  state_next = ST_NEAR_CAP;
      ST_NEAR_CAP: state_next = ST_OUT;
      ST_W_RD:     state_next = ST_W_GO;
      ST_W_GO:     state_next = ST_W_WAIT;
      ST_W_WAIT:   if (div_done) state_next = ST_MAC;
      ST_MAC: begin
        if (comp_idx == 4'(NUM_COMP)) state_next = k_last ? ST_A_GO : ST_W_RD;
      end
      ST_A_GO: state_next = ST_A_WAIT;
      ST_A_WAIT: begin
        if (div_done) state_next = (comp_idx == 4'(NUM_COMP - 1)) ? ST_SQ : ST_A_GO;
      end
      ST_SQ:        state_next = ST_LEN;
      ST_LEN:       state_next = (len2_sum == '0) ? ST_OUT : ST_SQRT_GO;
      ST_SQRT_GO:   state_next = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (sq_done) state_next = ST_N_GO;
      ST_N_GO:      state_next = ST_N_WAIT;
      ST_N_WAIT: begin
        if (div_done) state_next = (comp_idx == 4'd2) ? ST_OUT : ST_N_GO;
      end
      ST_OUT: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control strobes and operand selection.
  always_comb begin
    rd_issue     = 1'b0;
    ram_raddr    = scan_addr[ADDR_W-1:0];
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    div_neg_next = div_neg;
    sq_start     = 1'b0;
    case (state)
      ST_SCAN: rd_issue = 1'b1;
      ST_NEAR_RD: ram_raddr = bi[0];
      ST_W_RD: ram_raddr = bi[k[SLOT_W-1:0]];
      ST_W_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'({DVS_W'(bd[0]) + DVS_W'(EPS), WFRAC'(0)});
        div_divisor  = DVS_W'(bd[k[SLOT_W-1:0]]) + DVS_W'(EPS);
        div_neg_next = 1'b0;
      end
      ST_A_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(acc_mag + 64'(tot >> 1));
        div_divisor  = DVS_W'(tot);
        div_neg_next = acc[comp_idx[2:0]][63];
      end
      ST_SQRT_GO: sq_start = 1'b1;
      ST_N_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'({nmag, 28'b0}) + DIV_W'(len >> 1);
        div_divisor  = DVS_W'(len);
        div_neg_next = nrm[comp_idx[1:0]][16];
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      p0_v        <= 1'b0;
      p1_v        <= 1'b0;
      prod_v      <= 1'b0;
      sv          <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state  <= state_next;
      p0_v   <= rd_issue;
      p1_v   <= p0_v;
      prod_v <= (state == ST_MAC) && (comp_idx < 4'(NUM_COMP));
      if (s_acc && (s_tuser == KIND_CLEAR)) begin
        entry_count <= '0;
      end else if (ram_we) begin
        entry_count <= entry_count + CNT_W'(1);
      end
      // Each insert fills one more slot until the list is full.
      if (s_acc && (s_tuser == KIND_QUERY)) begin
        sv <= '0;
      end else if (p1_v) begin
        sv <= (sv << 1) | NEAREST_COUNT'(1);
      end
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Query datapath.
  always_ff @(posedge clk) begin
    div_neg <= div_neg_next;
    p0_idx  <= scan_addr[ADDR_W-1:0];
    p1_idx  <= p0_idx;
    sq_u    <= 50'(du * du);
    sq_v    <= 50'(dv * dv);
    prod    <= 64'($signed({1'b0, w}) * comp_val);
    prod_c  <= comp_idx[2:0];

    // Query start.
    if (s_acc && (s_tuser == KIND_QUERY)) begin
      qu        <= $signed(s_tdata[215:192]);
      qv        <= $signed(s_tdata[239:216]);
      scan_addr <= '0;
      k         <= '0;
      tot       <= '0;
      res_word  <= '0;
      res_empty <= (entry_count == '0);
      for (int c = 0; c < NUM_COMP; c++) begin
        acc[c] <= '0;
      end
    end

    if (rd_issue) begin
      scan_addr <= scan_addr + CNT_W'(1);
    end

    // Sorted insert of the new distance.
    if (p1_v) begin
      for (int p = 0; p < NEAREST_COUNT; p++) begin
        if (lt[p] && (p == 0 || !lt[(p == 0) ? 0 : p - 1])) begin
          bd[p] <= d_new;
          bi[p] <= p1_idx;
        end else if (p > 0 && lt[(p == 0) ? 0 : p - 1]) begin
          bd[p] <= bd[(p == 0) ? 0 : p - 1];
          bi[p] <= bi[(p == 0) ? 0 : p - 1];
        end
      end
    end

    // Accumulate the product of the previous cycle.
    if (prod_v) begin
      acc[prod_c] <= acc[prod_c] + prod;
    end

    case (state)
      ST_NEAR_CAP: res_word <= ram_rdata;
      ST_W_GO: ent <= ram_rdata;
      ST_W_WAIT: begin
        if (div_done) begin
          w        <= div_quo[WFRAC:0];
          comp_idx <= '0;
        end
      end
      ST_MAC: begin
        if (comp_idx == 4'(NUM_COMP)) begin
          tot      <= tot + TOT_W'(w);
          k        <= k + K_W'(1);
          comp_idx <= '0;
        end else begin
          comp_idx <= comp_idx + 4'd1;
        end
      end
      ST_A_WAIT: begin
        if (div_done) begin
          comp_idx <= comp_idx + 4'd1;
          case (comp_idx[2:0])
            3'd0: res_word[31:0]    <= div_res[31:0];
            3'd1: res_word[63:32]   <= div_res[31:0];
            3'd2: res_word[95:64]   <= div_res[31:0];
            3'd3: nrm[0]            <= div_res[16:0];
            3'd4: nrm[1]            <= div_res[16:0];
            3'd5: nrm[2]            <= div_res[16:0];
            3'd6: res_word[167:144] <= div_res[23:0];
            default: res_word[191:168] <= div_res[23:0];
          endcase
        end
      end
      ST_SQ: begin
        for (int c = 0; c < 3; c++) begin
          nsq[c] <= 34'(nrm[c] * nrm[c]);
        end
      end
      ST_LEN: begin
        len2 <= len2_sum;
        if (len2_sum == '0) begin
          res_word[111:96]  <= '0;
          res_word[127:112] <= NORM_ONE;
          res_word[143:128] <= '0;
        end
      end
      ST_SQRT_WAIT: begin
        if (sq_done) begin
          len      <= sq_root;
          comp_idx <= '0;
        end
      end
      ST_N_WAIT: begin
        if (div_done) begin
          comp_idx <= comp_idx + 4'd1;
          case (comp_idx[1:0])
            2'd0: res_word[111:96]  <= nclamp[15:0];
            2'd1: res_word[127:112] <= nclamp[15:0];
            default: res_word[143:128] <= nclamp[15:0];
          endcase
        end
      end
      default: ;
    endcase

    // Output register.
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= res_word;
      m_tuser <= res_empty;
    end
  end

  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, entry_count <= CNT_W'(MAX_ENTRIES))
  `ASSERT_IMPLIES(a_div_idle, clk, rst, div_start, !div_busy)
  `ASSERT_NEXT(a_load_count, clk, rst, ram_we, entry_count == $past(entry_count) + CNT_W'(1))
  `ASSERT_IMPLIES(a_empty_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata == '0)

endmodule
